// ----- hw/rtl/kaa_pkg.sv -----
// Shared constants, types and helpers of the k-means assignment unit.
package kaa_pkg;

    localparam int MAX_CLUSTERS = 16;
    localparam int MAX_DIMS     = 16;
    localparam int COORD_W      = 16;
    localparam int COUNT_W      = 16;

    localparam int ACTION_W  = 2;
    localparam int CLUSTER_W = 4;
    localparam int DIM_W     = 4;
    localparam int DIST_W    = 37;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 5;
    localparam int SQ_W      = 2 * (COORD_W + 1);

    localparam int CL_W   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int ADDR_W = CL_W + DM_W;
    localparam int CNT_W  = $clog2(((MAX_CLUSTERS > MAX_DIMS) ? MAX_CLUSTERS : MAX_DIMS) + 1);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [ACTION_W-1:0] {
        A_CENT  = 2'd0,
        A_POINT = 2'd1,
        A_CLEAR = 2'd2,
        A_READ  = 2'd3
    } t_action;

    typedef enum logic {
        K_ASSIGN = 1'b0,
        K_READ   = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_DRAIN,
        S_MIN,
        S_SUM,
        S_SUMW,
        S_RB
    } t_state;

    typedef struct packed {
        logic            cent_wr;
        logic            pbuf_wr;
        logic            accept;
        logic            clear;
        logic            dist_vld;
        logic [CL_W-1:0] dist_k;
        logic            min_vld;
        logic [CL_W-1:0] min_k;
        logic            sum_vld;
        logic [DM_W-1:0] sum_d;
        logic            load_assign;
        logic            load_rb;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_status;

    // saturate a raw register value into 1..hi
    function automatic logic [CNT_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v, input int hi);
        logic [CNT_W-1:0] r;
        if (v == '0) r = CNT_W'(1);
        else if (int'(v) > hi) r = CNT_W'(hi);
        else r = CNT_W'(v);
        return r;
    endfunction

endpackage

// ----- hw/rtl/kaa_item_if.sv -----
// Input channel carrying one command word.
interface kaa_item_if;
    import kaa_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [CLUSTER_W-1:0]       cluster;
    logic [DIM_W-1:0]           dim;
    logic signed [COORD_W-1:0]  value;
    modport source (output valid, action, cluster, dim, value, input ready);
    modport sink   (input valid, action, cluster, dim, value, output ready);
endinterface

// ----- hw/rtl/kaa_result_if.sv -----
// Output channel carrying one result word.
interface kaa_result_if;
    import kaa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      reply_kind;
    logic [CLUSTER_W-1:0]      membership;
    logic [DIST_W-1:0]         min_distance;
    logic signed [SUM_W-1:0]   sum_value;
    logic [COUNT_W-1:0]        member_count;
    modport source (output valid, reply_kind, membership, min_distance, sum_value,
                    member_count, input ready);
    modport sink   (input valid, reply_kind, membership, min_distance, sum_value,
                    member_count, output ready);
endinterface

// ----- hw/rtl/kmeans_assign_accumulate_unit.sv -----
// Top level of the k-means assignment and accumulation unit.
//
//  channel   dir  handshake        word
//  i_item    in   valid/ready      action, cluster, dim, value
//  o_result  out  valid/ready      reply_kind, membership, min_distance, sum_value, member_count
//  i_cfg_*   in   write enable     index 0 dims_in_use, 1 clusters_in_use
//
// One word at a time. Centroid write and clear finish in S_IDLE; readback passes through S_RB.
// Point coordinate: one shared multiply-accumulate per cluster, three-stage pipe; the last
// coordinate adds an argmin pass over the clusters, a sum update per dim and the result load.
// Reset is synchronous; no clearing pass. A word waits while a result is unread.
module kmeans_assign_accumulate_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [kaa_pkg::CFG_W-1:0]  i_cfg_data,
    kaa_item_if.sink                   i_item,
    kaa_result_if.source               o_result
);
    import kaa_pkg::*;

    t_cmd    cmd;
    t_status status;

    kaa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_item.valid),
        .i_action   (i_item.action),
        .i_dim      (i_item.dim),
        .o_ready    (i_item.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    kaa_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cluster (i_item.cluster),
        .i_dim     (i_item.dim),
        .i_value   (i_item.value),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_result  (o_result)
    );

endmodule

// ----- hw/rtl/kaa_ctrl.sv -----
// Sequencer: configuration registers, phase state machine and loop counters.
module kaa_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [kaa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic [kaa_pkg::ACTION_W-1:0]  i_action,
    input  logic [kaa_pkg::DIM_W-1:0]     i_dim,
    output logic                          o_ready,
    input  kaa_pkg::t_status              i_status,
    output kaa_pkg::t_cmd                 o_cmd
);
    import kaa_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic [CFG_W-1:0] r_dims, r_clusters;
    logic [CNT_W-1:0] nd, nc;
    logic             accept;

    assign nd = clamp_cfg(r_dims, MAX_DIMS);
    assign nc = clamp_cfg(r_clusters, MAX_CLUSTERS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims     <= CFG_W'(16);
            r_clusters <= CFG_W'(16);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 1'b0) r_dims <= i_cfg_data;
            else r_clusters <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        o_cmd   = '0;
        o_ready = 1'b0;
        accept  = 1'b0;
        o_cmd.dist_k = r_cnt[CL_W-1:0];
        o_cmd.min_k  = r_cnt[CL_W-1:0];
        o_cmd.sum_d  = r_cnt[DM_W-1:0];
        case (r_state)
            S_IDLE: begin
                o_ready = !i_status.out_busy;
                accept  = o_ready && i_valid;
                o_cmd.accept = accept;
                if (accept) begin
                    case (t_action'(i_action))
                        A_CENT:  o_cmd.cent_wr = 1'b1;
                        A_POINT: begin
                            if (CNT_W'(i_dim) < nd) begin
                                o_cmd.pbuf_wr = 1'b1;
                                n_last  = (CNT_W'(i_dim) == nd - CNT_W'(1));
                                n_cnt   = '0;
                                n_state = S_DIST;
                            end
                        end
                        A_CLEAR: o_cmd.clear = 1'b1;
                        A_READ: begin
                            n_state = S_RB;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIST: begin
                o_cmd.dist_vld = 1'b1;
                if (r_cnt == nc - CNT_W'(1)) begin
                    n_cnt   = '0;
                    n_state = S_DRAIN;
                end else n_cnt = r_cnt + CNT_W'(1);
            end
            // wait for the multiply-accumulate pipe to empty
            S_DRAIN: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = '0;
                    n_state = r_last ? S_MIN : S_IDLE;
                end else n_cnt = r_cnt + CNT_W'(1);
            end
            S_MIN: begin
                o_cmd.min_vld = 1'b1;
                if (r_cnt == nc - CNT_W'(1)) begin
                    n_cnt   = '0;
                    n_state = S_SUM;
                end else n_cnt = r_cnt + CNT_W'(1);
            end
            S_SUM: begin
                o_cmd.sum_vld = 1'b1;
                if (r_cnt == nd - CNT_W'(1)) n_state = S_SUMW;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            S_SUMW: begin
                o_cmd.load_assign = 1'b1;
                n_state = S_IDLE;
            end
            S_RB: begin
                o_cmd.load_rb = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/kaa_dp.sv -----
// Datapath: centroid and sum memories, distance MAC, argmin, counts, result register.
module kaa_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [kaa_pkg::CLUSTER_W-1:0]      i_cluster,
    input  logic [kaa_pkg::DIM_W-1:0]          i_dim,
    input  logic signed [kaa_pkg::COORD_W-1:0] i_value,
    input  kaa_pkg::t_cmd                      i_cmd,
    output kaa_pkg::t_status                   o_status,
    kaa_result_if.source                       o_result
);
    import kaa_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic signed [COORD_W-1:0] r_cent_mem [DEPTH];
    logic signed [SUM_W-1:0]   r_sum_mem  [DEPTH];
    logic [DEPTH-1:0]          r_sum_ok;
    logic signed [COORD_W-1:0] r_pbuf [MAX_DIMS];
    logic [DIST_W-1:0]         r_acc  [MAX_CLUSTERS];
    logic [COUNT_W-1:0]        r_count [MAX_CLUSTERS];

    logic [CL_W-1:0]           r_cl;
    logic [DM_W-1:0]           r_dm;
    logic signed [COORD_W-1:0] r_val;

    logic signed [COORD_W-1:0] r_cent;
    logic                      r_v1, r_v2;
    logic [CL_W-1:0]           r_k1, r_k2;
    logic [SQ_W-1:0]           r_sq;

    logic [CL_W-1:0]           r_best;
    logic [DIST_W-1:0]         r_bestd;

    logic signed [SUM_W-1:0]   r_rd;
    logic                      r_rdok;
    logic                      r_wv;
    logic [DM_W-1:0]           r_wd;

    logic                      r_out_valid;
    logic                      r_kind;
    logic [CLUSTER_W-1:0]      r_memb;
    logic [DIST_W-1:0]         r_dist;
    logic signed [SUM_W-1:0]   r_osum;
    logic [COUNT_W-1:0]        r_ocnt;

    logic [ADDR_W-1:0]         cent_wa, cent_ra, sum_ra, sum_wa;
    logic signed [COORD_W:0]   diff;
    logic signed [SQ_W-1:0]    sq_full;
    logic [DIST_W:0]           acc_sum;
    logic [DIST_W-1:0]         acc_base, acc_new;
    logic signed [SUM_W-1:0]   rd_val, sum_new;
    logic signed [SUM_W:0]     sum_wide;

    assign cent_wa = {i_cluster[CL_W-1:0], i_dim[DM_W-1:0]};
    assign cent_ra = {i_cmd.dist_k, r_dm};
    assign sum_ra  = i_cmd.sum_vld ? {r_best, i_cmd.sum_d}
                                   : {i_cluster[CL_W-1:0], i_dim[DM_W-1:0]};
    assign sum_wa  = {r_best, r_wd};

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cl  <= i_cluster[CL_W-1:0];
            r_dm  <= i_dim[DM_W-1:0];
            r_val <= i_value;
        end
        if (i_cmd.pbuf_wr) r_pbuf[i_dim[DM_W-1:0]] <= i_value;
    end

    // centroid memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.cent_wr) r_cent_mem[cent_wa] <= i_value;
        r_cent <= r_cent_mem[cent_ra];
    end

    // distance pipe: read, square, accumulate
    assign diff    = (COORD_W+1)'(r_val) - (COORD_W+1)'(r_cent);
    assign sq_full = diff * diff;
    assign acc_base = (r_dm == '0) ? '0 : r_acc[r_k2];
    assign acc_sum  = (DIST_W+1)'(acc_base) + (DIST_W+1)'(r_sq);
    assign acc_new  = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.dist_vld;
            r_v2 <= r_v1;
        end
        r_k1 <= i_cmd.dist_k;
        r_k2 <= r_k1;
        r_sq <= SQ_W'(unsigned'(sq_full));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) r_acc[c] <= '0;
        end else if (r_v2) begin
            r_acc[r_k2] <= acc_new;
        end
    end

    // argmin, strict less-than keeps the lowest index on ties
    always_ff @(posedge i_clk) begin
        if (i_cmd.min_vld) begin
            if (i_cmd.min_k == '0 || r_acc[i_cmd.min_k] < r_bestd) begin
                r_best  <= i_cmd.min_k;
                r_bestd <= r_acc[i_cmd.min_k];
            end
        end
    end

    // coordinate sums: read then saturating write in the following cycle
    assign rd_val   = r_rdok ? r_rd : '0;
    assign sum_wide = (SUM_W+1)'(rd_val) + (SUM_W+1)'(r_pbuf[r_wd]);
    assign sum_new  = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    ? {sum_wide[SUM_W], {(SUM_W-1){~sum_wide[SUM_W]}}}
                    : sum_wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        r_rd   <= r_sum_mem[sum_ra];
        r_rdok <= r_sum_ok[sum_ra];
        r_wd   <= i_cmd.sum_d;
        if (r_wv) r_sum_mem[sum_wa] <= sum_new;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv     <= 1'b0;
            r_sum_ok <= '0;
        end else begin
            r_wv <= i_cmd.sum_vld;
            if (i_cmd.clear) r_sum_ok <= '0;
            else if (r_wv) r_sum_ok[sum_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int c = 0; c < MAX_CLUSTERS; c++) r_count[c] <= '0;
        end else if (i_cmd.load_assign && r_count[r_best] != '1) begin
            r_count[r_best] <= r_count[r_best] + COUNT_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_assign || i_cmd.load_rb) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.load_assign) begin
            r_kind <= K_ASSIGN;
            r_memb <= CLUSTER_W'(r_best);
            r_dist <= r_bestd;
            r_osum <= '0;
            r_ocnt <= '0;
        end else if (i_cmd.load_rb) begin
            r_kind <= K_READ;
            r_memb <= '0;
            r_dist <= '0;
            r_osum <= rd_val;
            r_ocnt <= r_count[r_cl];
        end
    end

    assign o_status.out_busy     = r_out_valid;
    assign o_result.valid        = r_out_valid;
    assign o_result.reply_kind   = r_kind;
    assign o_result.membership   = r_memb;
    assign o_result.min_distance = r_dist;
    assign o_result.sum_value    = r_osum;
    assign o_result.member_count = r_ocnt;

endmodule
